// ===== rtl/sibs_pkg.sv =====
// ----------------------------------------------------------------------------
// sibs_pkg
// Shared types and constants for the signed integer to base symbols unit.
// ----------------------------------------------------------------------------
package sibs_pkg;

  localparam int MAX_SYMBOLS = 32;
  localparam int SYM_W       = 8;
  localparam int IDX_W       = $clog2(MAX_SYMBOLS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int VAL_W       = 32;
  localparam int SLICE_W     = 8;
  localparam int DIV_STEPS   = VAL_W / SLICE_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int BASE_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_8     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_16    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_24    = 3'd4;

  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [BASE_W-1:0]     BASE_SIZE_RST = 6'd10;
  localparam logic [CFG_DATA_W-1:0] SYM_0_RST     = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] SYM_8_RST     = 64'h0000000000003938;

  typedef logic [MAX_SYMBOLS-1:0][SYM_W-1:0] sym_tab_t;

  typedef struct packed {
    logic             neg;
    logic [VAL_W-1:0] mag;
    logic [CNT_W-1:0] len;
    logic             invalid;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/sibs_front.sv =====
// ----------------------------------------------------------------------------
// sibs_front
// Accepts an input item, forms sign and magnitude, and scans the alphabet
// one symbol a cycle for its length and validity.
// ----------------------------------------------------------------------------
module sibs_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [sibs_pkg::VAL_W-1:0]            s_tdata,
  input  logic [sibs_pkg::BASE_W-1:0]           base_size,
  input  sibs_pkg::sym_tab_t                    syms,
  output logic                                  push,
  output sibs_pkg::job_t                        job,
  input  sibs_pkg::q_stat_t                     q_stat
);
  import sibs_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SCAN = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic             neg;
  logic [VAL_W-1:0] mag;
  logic [CNT_W-1:0] idx;
  logic             bad;
  logic [CNT_W-1:0] lim;
  logic [SYM_W-1:0] cur;
  logic             stop;
  logic             dup;

  assign lim  = (base_size > BASE_W'(MAX_SYMBOLS)) ? CNT_W'(MAX_SYMBOLS)
                                                   : CNT_W'(base_size);
  assign cur  = syms[idx[IDX_W-1:0]];
  assign stop = (idx == lim) || (idx == CNT_W'(MAX_SYMBOLS)) || (cur == '0);

  // compare the current symbol against every earlier one in parallel
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if ((CNT_W'(j) < idx) && (syms[j] == cur)) begin
        dup = 1'b1;
      end
    end
  end

  assign s_tready = (state == F_IDLE);
  assign push     = (state == F_PUSH) && !q_stat.full;

  assign job.neg     = neg;
  assign job.mag     = mag;
  assign job.len     = idx;
  assign job.invalid = bad || (idx < CNT_W'(2));

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (s_tvalid) state_next = F_SCAN;
      F_SCAN: if (stop) state_next = F_PUSH;
      F_PUSH: if (!q_stat.full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      neg <= s_tdata[VAL_W-1];
      mag <= s_tdata[VAL_W-1] ? (~s_tdata + VAL_W'(1)) : s_tdata;
      idx <= '0;
      bad <= 1'b0;
    end else if ((state == F_SCAN) && !stop) begin
      bad <= bad || dup || (cur == CHAR_PLUS) || (cur == CHAR_MINUS);
      idx <= idx + CNT_W'(1);
    end
  end

endmodule

// ===== rtl/sibs_queue.sv =====
// ----------------------------------------------------------------------------
// sibs_queue
// Short job queue between the classifying front and the converting back.
// ----------------------------------------------------------------------------
module sibs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sibs_pkg::job_t     push_job,
  input  logic               pop,
  output sibs_pkg::job_t     head_job,
  output sibs_pkg::q_stat_t  q_stat
);
  import sibs_pkg::*;

  job_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign q_stat.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < Q_CNT_W'(Q_DEPTH)) || pop)
    else $error("job queue written while full");
`endif

endmodule

// ===== rtl/sibs_back.sv =====
// ----------------------------------------------------------------------------
// sibs_back
// Converts one job: repeated division by the radix, eight quotient bits a
// cycle, digits kept on a stack, then emitted most significant first.
// ----------------------------------------------------------------------------
module sibs_back (
  input  logic                        clk,
  input  logic                        rst,
  input  sibs_pkg::sym_tab_t          syms,
  input  sibs_pkg::job_t              head_job,
  input  sibs_pkg::q_stat_t           q_stat,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sibs_pkg::SYM_W-1:0]  m_tdata,
  output logic                        m_tlast,
  output logic                        m_tuser
);
  import sibs_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DIV  = 3'd1;
  localparam logic [2:0] B_SIGN = 3'd2;
  localparam logic [2:0] B_EMIT = 3'd3;
  localparam logic [2:0] B_INV  = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic               neg;
  logic [CNT_W-1:0]   len;
  logic [VAL_W-1:0]   w;
  logic [VAL_W-1:0]   w_next;
  logic [IDX_W-1:0]   rem;
  logic [IDX_W-1:0]   rem_next;
  logic [SLICE_W-1:0] qbits;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   sp;
  logic [CNT_W-1:0]   sp_m1;
  logic [SYM_W-1:0]   stack [MAX_SYMBOLS];
  logic               out_free;
  logic               load;
  logic [SYM_W-1:0]   load_sym;
  logic               load_last;
  logic               load_inv;
  logic               digit_done;

  assign out_free   = !m_tvalid || m_tready;
  assign pop        = (state == B_IDLE) && !q_stat.empty;
  assign sp_m1      = sp - CNT_W'(1);
  assign digit_done = (state == B_DIV) && (step == STEP_W'(DIV_STEPS - 1));

  // restoring division over the top slice of the working word
  always_comb begin
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] r;
    r     = rem;
    qbits = '0;
    for (int k = 0; k < SLICE_W; k++) begin
      t = {r, w[VAL_W-1-k]};
      if (t >= len) begin
        qbits[SLICE_W-1-k] = 1'b1;
        t                  = t - len;
      end
      r = t[IDX_W-1:0];
    end
    rem_next = r;
    w_next   = {w[VAL_W-SLICE_W-1:0], qbits};
  end

  always_comb begin
    load      = 1'b0;
    load_sym  = '0;
    load_last = 1'b0;
    load_inv  = 1'b0;
    unique case (state)
      B_SIGN: begin
        load     = out_free;
        load_sym = CHAR_MINUS;
      end
      B_EMIT: begin
        load      = out_free;
        load_sym  = stack[sp_m1[IDX_W-1:0]];
        load_last = (sp == CNT_W'(1));
      end
      B_INV: begin
        load      = out_free;
        load_last = 1'b1;
        load_inv  = 1'b1;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (pop) state_next = head_job.invalid ? B_INV : B_DIV;
      B_DIV:  if (digit_done && (w_next == '0)) state_next = neg ? B_SIGN : B_EMIT;
      B_SIGN: if (out_free) state_next = B_EMIT;
      B_EMIT: if (out_free && (sp == CNT_W'(1))) state_next = B_IDLE;
      B_INV:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      sp       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        sp <= '0;
      end else if (digit_done) begin
        sp <= sp + CNT_W'(1);
      end else if ((state == B_EMIT) && out_free) begin
        sp <= sp_m1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      neg  <= head_job.neg;
      len  <= head_job.len;
      w    <= head_job.mag;
      rem  <= '0;
      step <= '0;
    end else if (state == B_DIV) begin
      w    <= w_next;
      step <= step + STEP_W'(1);
      rem  <= digit_done ? '0 : rem_next;
    end
    if (digit_done) begin
      stack[sp[IDX_W-1:0]] <= syms[rem_next];
    end
    if (load) begin
      m_tdata <= load_sym;
      m_tlast <= load_last;
      m_tuser <= load_inv;
    end
  end

`ifndef SYNTHESIS
  a_inv_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
    else $error("invalid-base item must be a lone zero with last");
  a_div_radix: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (len >= CNT_W'(2)))
    else $error("division started with a radix below two");
  a_stack_depth: assert property (@(posedge clk) disable iff (rst)
    sp <= CNT_W'(MAX_SYMBOLS))
    else $error("digit stack overflow");
`endif

endmodule

// ===== rtl/signed_int_to_base_symbols_unit.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_base_symbols_unit
// Writes signed 32-bit values out as symbol bytes in a configured radix.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  value
//   m_*      out  m_tvalid/m_tready  symbol, last, invalid_base
//   cfg_*    in   cfg_we             register index, data
//
// The front scans the alphabet one symbol a cycle to find len and validity.
// The back divides the whole word for each digit, 8 quotient bits a cycle
// through the divider, then emits one output symbol a cycle while m_tready allows.
// Front and back overlap across items through a two-entry job queue.
// Reset is synchronous; config takes effect from reset values right away.
// A stalled output holds the back; the front keeps going until the queue fills.
// ----------------------------------------------------------------------------
module signed_int_to_base_symbols_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [sibs_pkg::VAL_W-1:0]           s_tdata,    // value
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sibs_pkg::SYM_W-1:0]           m_tdata,    // symbol
  output logic                                 m_tlast,
  output logic                                 m_tuser,    // invalid_base
  input  logic                                 cfg_we,
  input  logic [sibs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sibs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sibs_pkg::*;

  logic [BASE_W-1:0] base_size;
  sym_tab_t          syms;
  logic              push;
  logic              pop;
  job_t              push_job;
  job_t              head_job;
  q_stat_t           q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_size   <= BASE_SIZE_RST;
      syms[7:0]   <= SYM_0_RST;
      syms[15:8]  <= SYM_8_RST;
      syms[23:16] <= '0;
      syms[31:24] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_SIZE: base_size   <= cfg_data[BASE_W-1:0];
        CFG_SYM_0:     syms[7:0]   <= cfg_data;
        CFG_SYM_8:     syms[15:8]  <= cfg_data;
        CFG_SYM_16:    syms[23:16] <= cfg_data;
        CFG_SYM_24:    syms[31:24] <= cfg_data;
        default: begin
          base_size <= base_size;
        end
      endcase
    end
  end

  sibs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .base_size (base_size),
    .syms      (syms),
    .push      (push),
    .job       (push_job),
    .q_stat    (q_stat)
  );

  sibs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  sibs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .syms     (syms),
    .head_job (head_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
